// ===== sv/gluc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gluc_pkg
// Shared types and codes of the gradient lookup colorizer: request and pixel
// payloads, configuration register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package gluc_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_LOWER   = 2'd0,
        CFG_INDEX_SCALE   = 2'd1,
        CFG_PERIODIC_MODE = 2'd2
    } t_cfg_idx;

    localparam logic ACT_WRITE    = 1'b0;
    localparam logic ACT_COLORIZE = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [31:0] sample_value;
        logic [7:0]         sample_alpha;
        logic               row_end;
        logic [7:0]         entry_index;
        logic [31:0]        entry_color;
    } t_req;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic        row_end_out;
    } t_pix;

    typedef struct packed {
        logic signed [31:0] range_lower;
        logic [31:0]        index_scale;
        logic               periodic_mode;
    } t_cfg;

    // request fields that ride along with the index computation
    typedef struct packed {
        logic        action;
        logic [7:0]  alpha;
        logic        row_end;
        logic [7:0]  entry_index;
        logic [31:0] entry_color;
    } t_side;

endpackage
`default_nettype wire

// ===== sv/gluc_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gluc_req_if / gluc_pix_if
// Valid/ready channels of the colorizer: requests in, pixels out.
// ----------------------------------------------------------------------------
interface gluc_req_if;
    import gluc_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gluc_pix_if;
    import gluc_pkg::*;
    logic valid;
    logic ready;
    t_pix data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/gradient_lut_colorize_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_lut_colorize_unit
// Pseudocolor mapper: table write requests load ARGB entries, sample requests
// map a value through the scaled, clamped or wrapped index to an entry and
// scale its channels by the sample alpha.
// ----------------------------------------------------------------------------
// throughput: one request per cycle while the pixel output is ready; the six index stages,
//   the table read stage and the two alpha stages each have their own valid bit
// write requests update the table at the read stage and give no pixel
// reset clears all valid bits and the config registers; the table is not
//   cleared and no startup pass runs
// ----------------------------------------------------------------------------
module gradient_lut_colorize_unit #(
    parameter int LEVELS = 256
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    gluc_req_if.sink                             i_req,
    gluc_pix_if.source                           o_pix,
    input  wire logic                            i_cfg_we,
    input  wire logic [gluc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gluc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import gluc_pkg::*;

    localparam int AW = $clog2(LEVELS);

    t_cfg r_cfg;

    logic          idx_valid;
    t_side         idx_side;
    logic [AW-1:0] idx_addr;

    logic          en7;
    logic          shade_rdy;
    logic          r_v7;
    logic [7:0]    r_alpha7;
    logic          r_row7;
    logic          ram_we;
    logic          wr_ok;
    logic [31:0]   ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_lower   <= '0;
            r_cfg.index_scale   <= 32'd65536;
            r_cfg.periodic_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RANGE_LOWER:   r_cfg.range_lower   <= i_cfg_data;
                CFG_INDEX_SCALE:   r_cfg.index_scale   <= i_cfg_data;
                CFG_PERIODIC_MODE: r_cfg.periodic_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    gluc_index #(.LEVELS(LEVELS)) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cfg   (r_cfg),
        .i_ready (en7),
        .o_valid (idx_valid),
        .o_side  (idx_side),
        .o_addr  (idx_addr)
    );

    // table read stage
    assign en7    = !r_v7 || shade_rdy;
    assign wr_ok  = (32'(idx_side.entry_index) < 32'(LEVELS));
    assign ram_we = en7 && idx_valid && (idx_side.action == ACT_WRITE) && wr_ok;

    gluc_ram #(.WIDTH(32), .DEPTH(LEVELS)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(idx_side.entry_index)),
        .i_wdata (idx_side.entry_color),
        .i_re    (en7),
        .i_raddr (idx_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else if (en7) begin
            r_v7 <= idx_valid && (idx_side.action == ACT_COLORIZE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en7) begin
            r_alpha7 <= idx_side.alpha;
            r_row7   <= idx_side.row_end;
        end
    end

    gluc_shade u_shade (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_v7),
        .i_color   (ram_rdata),
        .i_alpha   (r_alpha7),
        .i_row_end (r_row7),
        .o_ready   (shade_rdy),
        .o_pix     (o_pix)
    );

    a_write_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> !r_v7)
        else $error("table write turned into a pixel");

    a_read_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v7 && !shade_rdy) |=> (r_v7 && $stable(ram_rdata)))
        else $error("table read data lost during stall");

    a_slot_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (idx_valid && (idx_side.action == ACT_COLORIZE)) |-> (32'(idx_addr) < 32'(LEVELS)))
        else $error("table slot out of range");

endmodule
`default_nettype wire

// ===== sv/gluc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gluc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gluc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== sv/gluc_index.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gluc_index
// Six-stage table index pipeline: offset, Q16.16 scale, saturation,
// reciprocal remainder and clamp or wrap to a table slot.
// ----------------------------------------------------------------------------
module gluc_index #(
    parameter int LEVELS = 256
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    gluc_req_if.sink                       i_req,
    input  wire gluc_pkg::t_cfg            i_cfg,
    input  wire logic                      i_ready,
    output logic                           o_valid,
    output gluc_pkg::t_side                o_side,
    output logic [$clog2(LEVELS)-1:0]      o_addr
);

    import gluc_pkg::*;

    localparam int AW = $clog2(LEVELS);
    localparam int RW = AW + 1;
    localparam logic [63:0] RECIP64 = (64'd1 << 32) / 64'(LEVELS);
    localparam logic [31:0] RECIP   = RECIP64[31:0];
    localparam logic [31:0] LEV32   = 32'(LEVELS);
    localparam logic [RW-1:0] LEV_R = RW'(LEVELS);
    localparam logic [AW-1:0] TOP_SLOT = AW'(LEVELS - 1);
    localparam logic [47:0] POS_MAX = 48'h0000_7FFF_FFFF;
    localparam logic [47:0] NEG_MAX = 48'h0000_8000_0000;

    logic en1, en2, en3, en4, en5, en6;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    t_side r_sd1, r_sd2, r_sd3, r_sd4, r_sd5, r_sd6;
    logic r_neg1, r_neg2, r_neg3, r_neg4, r_neg5;

    logic [31:0]    r_mag1;
    logic [63:0]    r_prod2;
    logic [31:0]    r_sat3, r_sat4;
    logic [63:0]    r_qp4;
    logic           r_big4, r_big5;
    logic [RW-1:0]  r_rem5;
    logic [AW-1:0]  r_low5;
    logic [AW-1:0]  r_addr6;

    logic [32:0]    n_diff;
    logic [32:0]    n_ndiff;
    logic [31:0]    n_mag1;
    logic [63:0]    n_prod2;
    logic [47:0]    n_q3;
    logic [31:0]    n_sat3;
    logic [63:0]    n_qp4;
    logic [31:0]    n_qest5;
    logic [31:0]    n_rem5w;
    logic [RW-1:0]  n_rem6;
    logic [AW-1:0]  n_wrap6;
    logic [AW-1:0]  n_clamp6;
    logic [AW-1:0]  n_addr6;
    t_side          n_sd1;

    assign en6 = !r_v6 || i_ready;
    assign en5 = !r_v5 || en6;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_req.ready = en1;

    always_comb begin
        n_diff  = {i_req.data.sample_value[31], i_req.data.sample_value}
                - {i_cfg.range_lower[31], i_cfg.range_lower};
        n_ndiff = 33'd0 - n_diff;
        n_mag1  = n_diff[32] ? n_ndiff[31:0] : n_diff[31:0];
        n_sd1.action      = i_req.data.action;
        n_sd1.alpha       = i_req.data.sample_alpha;
        n_sd1.row_end     = i_req.data.row_end;
        n_sd1.entry_index = i_req.data.entry_index;
        n_sd1.entry_color = i_req.data.entry_color;
    end

    assign n_prod2 = r_mag1 * i_cfg.index_scale;

    always_comb begin
        n_q3 = r_prod2[63:16];
        if (r_neg2) begin
            n_sat3 = (n_q3 > NEG_MAX) ? NEG_MAX[31:0] : n_q3[31:0];
        end else begin
            n_sat3 = (n_q3 > POS_MAX) ? POS_MAX[31:0] : n_q3[31:0];
        end
    end

    assign n_qp4   = r_sat3 * RECIP;
    assign n_qest5 = r_qp4[63:32];
    assign n_rem5w = r_sat4 - 32'(n_qest5 * LEV32);

    // remainder estimate is below twice the table size
    always_comb begin
        n_rem6   = (r_rem5 >= LEV_R) ? (r_rem5 - LEV_R) : r_rem5;
        n_wrap6  = (r_neg5 && (n_rem6 != '0)) ? AW'(LEV_R - n_rem6) : AW'(n_rem6);
        n_clamp6 = r_neg5 ? '0 : (r_big5 ? TOP_SLOT : r_low5);
        n_addr6  = i_cfg.periodic_mode ? n_wrap6 : n_clamp6;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_req.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_sd1  <= n_sd1;
            r_neg1 <= n_diff[32];
            r_mag1 <= n_mag1;
        end
        if (en2) begin
            r_sd2   <= r_sd1;
            r_neg2  <= r_neg1;
            r_prod2 <= n_prod2;
        end
        if (en3) begin
            r_sd3  <= r_sd2;
            r_neg3 <= r_neg2;
            r_sat3 <= n_sat3;
        end
        if (en4) begin
            r_sd4  <= r_sd3;
            r_neg4 <= r_neg3;
            r_sat4 <= r_sat3;
            r_qp4  <= n_qp4;
            r_big4 <= (r_sat3 >= LEV32);
        end
        if (en5) begin
            r_sd5  <= r_sd4;
            r_neg5 <= r_neg4;
            r_rem5 <= n_rem5w[RW-1:0];
            r_low5 <= r_sat4[AW-1:0];
            r_big5 <= r_big4;
        end
        if (en6) begin
            r_sd6   <= r_sd5;
            r_addr6 <= n_addr6;
        end
    end

    assign o_valid = r_v6;
    assign o_side  = r_sd6;
    assign o_addr  = r_addr6;

endmodule
`default_nettype wire

// ===== sv/gluc_shade.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gluc_shade
// Two-stage alpha scaling of a table entry: per-channel products, then the
// exact divide by 255 into the output register.
// ----------------------------------------------------------------------------
module gluc_shade (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_color,
    input  wire logic [7:0]  i_alpha,
    input  wire logic        i_row_end,
    output logic             o_ready,
    gluc_pix_if.source       o_pix
);

    import gluc_pkg::*;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // exact floor(p / 255) for p up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = 17'(p) + 17'(p[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    logic en8, en9;
    logic r_v8, r_v9;
    logic r_opq8, r_row8;
    logic [31:0] r_raw8;
    logic [15:0] r_cp8 [4];
    t_pix r_pix9;
    t_pix n_pix9;

    assign en9 = !r_v9 || o_pix.ready;
    assign en8 = !r_v8 || en9;
    assign o_ready = en8;

    always_comb begin
        n_pix9.row_end_out = r_row8;
        for (int k = 0; k < 4; k++) begin
            n_pix9.pixel_color[k*8 +: 8] = r_opq8 ? r_raw8[k*8 +: 8] : div255(r_cp8[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
        end else begin
            if (en8) r_v8 <= i_valid;
            if (en9) r_v9 <= r_v8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en8) begin
            r_opq8 <= (i_alpha == ALPHA_OPAQUE);
            r_row8 <= i_row_end;
            r_raw8 <= i_color;
            for (int k = 0; k < 4; k++) begin
                r_cp8[k] <= i_color[k*8 +: 8] * i_alpha;
            end
        end
        if (en9) begin
            r_pix9 <= n_pix9;
        end
    end

    assign o_pix.valid = r_v9;
    assign o_pix.data  = r_pix9;

endmodule
`default_nettype wire
